// ----- src/acm_pkg.sv -----
// Shared types, codes and fixed widths for the agglomerative cluster merger.
// Used by acm_blend, agglomerative_cluster_merger_core and acm_checker.
`default_nettype none

package acm_pkg;

    localparam int IDX_W       = 6;
    localparam int SIZE_W      = 7;
    localparam int LVL_W       = 32;
    localparam int INDEX_LIMIT = 64;
    localparam int DIV_BITS    = 43;

    localparam logic [1:0] CFG_TECHNIQUE     = 2'd0;
    localparam logic [1:0] CFG_BETA          = 2'd1;
    localparam logic [1:0] CFG_OBJECT_COUNT  = 2'd2;
    localparam logic [1:0] CFG_GROUPS_WANTED = 2'd3;

    localparam logic [1:0] TECH_SINGLE   = 2'd0;
    localparam logic [1:0] TECH_COMPLETE = 2'd1;
    localparam logic [1:0] TECH_WPGMA    = 2'd2;
    localparam logic [1:0] TECH_UPGMA    = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] column_index;
        logic [LVL_W-1:0] distance;
        logic             last_entry;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] left_object;
        logic [IDX_W-1:0] right_object;
        logic [LVL_W-1:0] merge_level;
        logic             reaches_group_count;
        logic             last_merge;
    } t_out_item;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [IDX_W-1:0]  nn_idx;
        logic [LVL_W-1:0]  nn_lvl;
    } t_rec;

    typedef struct packed {
        logic [1:0]        technique;
        logic signed [15:0] beta;
        logic [LVL_W-1:0]  dl;
        logic [LVL_W-1:0]  dm;
        logic [LVL_W-1:0]  dlm;
        logic [SIZE_W-1:0] nl;
        logic [SIZE_W-1:0] nm;
    } t_blend_req;

    typedef enum logic [3:0] {
        BL_IDLE,
        BL_MUL_L,
        BL_MUL_M,
        BL_MUL_LO,
        BL_MUL_HI,
        BL_SUM,
        BL_BETA,
        BL_TOT,
        BL_NUM,
        BL_DIV,
        BL_SAT,
        BL_DONE
    } t_blend_state;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NR_ISSUE,
        ST_NR_WAIT,
        ST_INIT_WR,
        ST_ROUND,
        ST_PICK_ISSUE,
        ST_PICK_WAIT,
        ST_PAIR_WAIT,
        ST_EMIT,
        ST_K_ISSUE,
        ST_K_DL,
        ST_K_DM,
        ST_K_BLEND,
        ST_K_REC,
        ST_K_REFRESH,
        ST_K_END,
        ST_L_WR
    } t_core_state;

endpackage

`default_nettype wire

// ----- src/acm_blend.sv -----
// Lance-Williams distance update: min, max or flexible blend with rounding.
// Multi-cycle: one multiply per step, then a bit-serial divide by the pair size.
// Depends on acm_pkg.
`default_nettype none

module acm_blend (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire acm_pkg::t_blend_req     i_req,
    output logic                         o_done,
    output logic [acm_pkg::LVL_W-1:0]    o_value
);

    acm_pkg::t_blend_state r_state, n_state;
    acm_pkg::t_blend_req   r_req, n_req;
    logic [acm_pkg::SIZE_W-1:0] r_nl, n_nl, r_nm, n_nm;
    logic [39:0]                r_s, n_s;
    logic [36:0]                r_pa, n_pa, r_pb, n_pb;
    logic [57:0]                r_pos, n_pos;
    logic signed [48:0]         r_v, n_v;
    logic signed [57:0]         r_w, n_w;
    logic [7:0]                 r_rem, n_rem;
    logic [acm_pkg::DIV_BITS-1:0] r_q, n_q;
    logic [5:0]                 r_cnt, n_cnt;
    logic [acm_pkg::LVL_W-1:0]  r_value, n_value;

    logic [7:0]         tot;
    logic [16:0]        omb;
    logic signed [48:0] beta_x, dlm_x;
    logic signed [57:0] num;
    logic [57:0]        a_rnd;
    logic [8:0]         sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acm_pkg::BL_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_nl    <= n_nl;
        r_nm    <= n_nm;
        r_s     <= n_s;
        r_pa    <= n_pa;
        r_pb    <= n_pb;
        r_pos   <= n_pos;
        r_v     <= n_v;
        r_w     <= n_w;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_cnt   <= n_cnt;
        r_value <= n_value;
    end

    always_comb begin
        tot = 8'(r_nl) + 8'(r_nm);
        if (tot == 8'd0) begin
            tot = 8'd1;
        end
        // one minus beta in unsigned Q2.15, always 1..65536
        omb    = 17'(18'h08000 - {{2{r_req.beta[15]}}, r_req.beta});
        beta_x = 49'(r_req.beta);
        dlm_x  = $signed({17'd0, r_req.dlm});
        num    = $signed(r_pos) + r_w;
        a_rnd  = 58'(num) + (58'(tot) << 14);
        sh     = {r_rem, r_q[acm_pkg::DIV_BITS-1]};

        n_state = r_state;
        n_req   = r_req;
        n_nl    = r_nl;
        n_nm    = r_nm;
        n_s     = r_s;
        n_pa    = r_pa;
        n_pb    = r_pb;
        n_pos   = r_pos;
        n_v     = r_v;
        n_w     = r_w;
        n_rem   = r_rem;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_value = r_value;
        o_done  = 1'b0;

        case (r_state)
            acm_pkg::BL_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_nl  = i_req.nl;
                    n_nm  = i_req.nm;
                    case (i_req.technique)
                        acm_pkg::TECH_SINGLE: begin
                            n_value = (i_req.dl < i_req.dm) ? i_req.dl : i_req.dm;
                            n_state = acm_pkg::BL_DONE;
                        end
                        acm_pkg::TECH_COMPLETE: begin
                            n_value = (i_req.dl > i_req.dm) ? i_req.dl : i_req.dm;
                            n_state = acm_pkg::BL_DONE;
                        end
                        acm_pkg::TECH_WPGMA: begin
                            n_nl    = acm_pkg::SIZE_W'(1);
                            n_nm    = acm_pkg::SIZE_W'(1);
                            n_state = acm_pkg::BL_MUL_L;
                        end
                        default: begin
                            n_state = acm_pkg::BL_MUL_L;
                        end
                    endcase
                end
            end
            acm_pkg::BL_MUL_L: begin
                n_s     = 40'(r_nl) * 40'(r_req.dl);
                n_state = acm_pkg::BL_MUL_M;
            end
            acm_pkg::BL_MUL_M: begin
                n_s     = r_s + 40'(r_nm) * 40'(r_req.dm);
                n_state = acm_pkg::BL_MUL_LO;
            end
            acm_pkg::BL_MUL_LO: begin
                n_pa    = 37'(r_s[19:0]) * 37'(omb);
                n_state = acm_pkg::BL_MUL_HI;
            end
            acm_pkg::BL_MUL_HI: begin
                n_pb    = 37'(r_s[39:20]) * 37'(omb);
                n_state = acm_pkg::BL_SUM;
            end
            acm_pkg::BL_SUM: begin
                n_pos   = 58'(r_pa) + (58'(r_pb) << 20);
                n_state = acm_pkg::BL_BETA;
            end
            acm_pkg::BL_BETA: begin
                n_v     = beta_x * dlm_x;
                n_state = acm_pkg::BL_TOT;
            end
            acm_pkg::BL_TOT: begin
                n_w     = 58'(r_v) * $signed({50'd0, tot});
                n_state = acm_pkg::BL_NUM;
            end
            acm_pkg::BL_NUM: begin
                if (num <= 58'sd0) begin
                    n_value = '0;
                    n_state = acm_pkg::BL_DONE;
                end else begin
                    // round half up, drop the Q1.15 scale, then divide by the pair size
                    n_q     = a_rnd[57:15];
                    n_rem   = '0;
                    n_cnt   = 6'(acm_pkg::DIV_BITS);
                    n_state = acm_pkg::BL_DIV;
                end
            end
            acm_pkg::BL_DIV: begin
                if (sh >= {1'b0, tot}) begin
                    n_rem = 8'(sh - {1'b0, tot});
                    n_q   = {r_q[acm_pkg::DIV_BITS-2:0], 1'b1};
                end else begin
                    n_rem = sh[7:0];
                    n_q   = {r_q[acm_pkg::DIV_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    n_state = acm_pkg::BL_SAT;
                end
            end
            acm_pkg::BL_SAT: begin
                n_value = (|r_q[acm_pkg::DIV_BITS-1:32]) ? '1 : r_q[31:0];
                n_state = acm_pkg::BL_DONE;
            end
            acm_pkg::BL_DONE: begin
                o_done  = 1'b1;
                n_state = acm_pkg::BL_IDLE;
            end
            default: begin
                n_state = acm_pkg::BL_IDLE;
            end
        endcase
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- src/agglomerative_cluster_merger_core.sv -----
// Top level: matrix load, cluster sequencer, distance and cluster-record memories.
// Depends on acm_pkg and acm_blend.
//
//  channel   signals                                   direction
//  in        i_in_valid / o_in_ready / i_in_data       matrix entries in
//  out       o_out_valid / i_out_ready / o_out_data    merges out
//  cfg       i_cfg_we / i_cfg_index / i_cfg_data       register writes
//
// Matrix entries load at one per cycle into the distance memory while idle.
// The last entry starts a run of 2+ objects; entries are refused until it ends.
// A run reads the distance memory one entry at a time, first to find each
// cluster's nearest neighbour, then, per merge, 2 reads per remaining cluster and
// a blend in acm_blend: a serial divide for flexible links, min or max otherwise.
// Reset clears control state and registers; the distance memory is not cleared.
// A stalled output register holds the sequencer at the next merge.
`default_nettype none

module agglomerative_cluster_merger_core #(
    parameter int MAX_OBJECTS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire acm_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output acm_pkg::t_out_item      o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);

    localparam int LIMIT = (MAX_OBJECTS < acm_pkg::INDEX_LIMIT) ? MAX_OBJECTS
                                                                 : acm_pkg::INDEX_LIMIT;
    localparam int IW    = $clog2(LIMIT);
    localparam int CW    = $clog2(LIMIT + 1);
    localparam int SD    = LIMIT * (LIMIT - 1) / 2;
    localparam int AW    = $clog2(SD);

    function automatic logic [AW-1:0] f_slot(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW-1:0]   hi;
        logic [IW-1:0]   lo;
        logic [2*IW-1:0] p;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        p  = (2*IW)'(hi) * (2*IW)'(hi - IW'(1));
        return AW'(p >> 1) + AW'(lo);
    endfunction

    // configuration
    logic [1:0]         r_technique;
    logic signed [15:0] r_beta;
    logic [6:0]         r_obj_count;
    logic [6:0]         r_groups;

    // memories
    logic [acm_pkg::LVL_W-1:0] r_dmem [SD];
    logic [acm_pkg::LVL_W-1:0] r_d_rdata;
    logic                      d_we;
    logic [AW-1:0]             d_waddr, d_raddr;
    logic [acm_pkg::LVL_W-1:0] d_wdata;
    acm_pkg::t_rec             r_rmem [LIMIT];
    acm_pkg::t_rec             r_r_rdata;
    logic                      rm_we;
    logic [IW-1:0]             rm_waddr, rm_raddr;
    acm_pkg::t_rec             rm_wdata;

    // sequencer
    acm_pkg::t_core_state r_state, n_state, r_ret, n_ret;
    logic [CW-1:0]        r_n, n_n, r_left, n_left, r_x, n_x, r_y, n_y;
    logic [LIMIT-1:0]     r_active, n_active;
    logic [IW-1:0]        r_sx, n_sx, r_best_idx, n_best_idx;
    logic                 r_found, n_found;
    logic [acm_pkg::LVL_W-1:0] r_best_lvl, n_best_lvl;
    logic [IW-1:0]        r_pick, n_pick, r_pick_nn, n_pick_nn, r_l, n_l, r_m, n_m;
    logic                 r_pick_found, n_pick_found;
    logic [acm_pkg::LVL_W-1:0] r_pick_lvl, n_pick_lvl, r_lvl, n_lvl, r_dl, n_dl;
    logic [acm_pkg::LVL_W-1:0] r_nv, n_nv;
    logic [acm_pkg::SIZE_W-1:0] r_pick_size, n_pick_size, r_sl, n_sl, r_sm, n_sm;
    logic [acm_pkg::SIZE_W-1:0] r_rec_size, n_rec_size;
    acm_pkg::t_out_item   r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 bl_start, bl_done;
    acm_pkg::t_blend_req  bl_req;
    logic [acm_pkg::LVL_W-1:0] bl_value;

    logic [CW-1:0]        ncap, rem;
    logic [IW-1:0]        nr_idx, y_ix;
    logic [acm_pkg::LVL_W-1:0] nr_lvl;
    logic                 in_acc;

    acm_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bl_start),
        .i_req   (bl_req),
        .o_done  (bl_done),
        .o_value (bl_value)
    );

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_dmem[d_waddr] <= d_wdata;
        end
        r_d_rdata <= r_dmem[d_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rm_we) begin
            r_rmem[rm_waddr] <= rm_wdata;
        end
        r_r_rdata <= r_rmem[rm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_technique <= acm_pkg::TECH_UPGMA;
            r_beta      <= -16'sd3277;
            r_obj_count <= 7'd64;
            r_groups    <= 7'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                acm_pkg::CFG_TECHNIQUE:     r_technique <= i_cfg_data[1:0];
                acm_pkg::CFG_BETA:          r_beta      <= $signed(i_cfg_data);
                acm_pkg::CFG_OBJECT_COUNT:  r_obj_count <= i_cfg_data[6:0];
                acm_pkg::CFG_GROUPS_WANTED: r_groups    <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= acm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_active    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_left      <= n_left;
            r_active    <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret        <= n_ret;
        r_n          <= n_n;
        r_x          <= n_x;
        r_y          <= n_y;
        r_sx         <= n_sx;
        r_found      <= n_found;
        r_best_idx   <= n_best_idx;
        r_best_lvl   <= n_best_lvl;
        r_pick       <= n_pick;
        r_pick_found <= n_pick_found;
        r_pick_nn    <= n_pick_nn;
        r_pick_lvl   <= n_pick_lvl;
        r_pick_size  <= n_pick_size;
        r_l          <= n_l;
        r_m          <= n_m;
        r_sl         <= n_sl;
        r_sm         <= n_sm;
        r_lvl        <= n_lvl;
        r_dl         <= n_dl;
        r_nv         <= n_nv;
        r_rec_size   <= n_rec_size;
        r_out        <= n_out;
    end

    always_comb begin
        ncap   = (r_obj_count > 7'(LIMIT)) ? CW'(LIMIT) : CW'(r_obj_count);
        rem    = r_left - CW'(2);
        nr_idx = r_found ? r_best_idx : r_sx;
        nr_lvl = r_found ? r_best_lvl : '0;
        y_ix   = r_y[IW-1:0];
        in_acc = i_in_valid && o_in_ready;

        o_in_ready = (r_state == acm_pkg::ST_IDLE);

        n_state      = r_state;
        n_ret        = r_ret;
        n_n          = r_n;
        n_left       = r_left;
        n_x          = r_x;
        n_y          = r_y;
        n_active     = r_active;
        n_sx         = r_sx;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_lvl   = r_best_lvl;
        n_pick       = r_pick;
        n_pick_found = r_pick_found;
        n_pick_nn    = r_pick_nn;
        n_pick_lvl   = r_pick_lvl;
        n_pick_size  = r_pick_size;
        n_l          = r_l;
        n_m          = r_m;
        n_sl         = r_sl;
        n_sm         = r_sm;
        n_lvl        = r_lvl;
        n_dl         = r_dl;
        n_nv         = r_nv;
        n_rec_size   = r_rec_size;
        n_out        = r_out;
        n_out_valid  = (r_out_valid && i_out_ready) ? 1'b0 : r_out_valid;

        d_we     = 1'b0;
        d_waddr  = '0;
        d_wdata  = '0;
        d_raddr  = '0;
        rm_we    = 1'b0;
        rm_waddr = '0;
        rm_wdata = '0;
        rm_raddr = '0;
        bl_start = 1'b0;
        bl_req.technique = r_technique;
        bl_req.beta      = r_beta;
        bl_req.dl        = r_dl;
        bl_req.dm        = r_d_rdata;
        bl_req.dlm       = r_lvl;
        bl_req.nl        = r_sl;
        bl_req.nm        = r_sm;

        case (r_state)
            acm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if ((i_in_data.column_index < i_in_data.row_index)
                            && (7'(i_in_data.row_index) < 7'(ncap))) begin
                        d_we    = 1'b1;
                        d_waddr = f_slot(IW'(i_in_data.row_index), IW'(i_in_data.column_index));
                        d_wdata = i_in_data.distance;
                    end
                    if (i_in_data.last_entry) begin
                        n_n    = ncap;
                        n_left = ncap;
                        if (ncap >= CW'(2)) begin
                            for (int i = 0; i < LIMIT; i++) begin
                                n_active[i] = (CW'(i) < ncap);
                            end
                            n_x     = '0;
                            n_sx    = '0;
                            n_y     = '0;
                            n_found = 1'b0;
                            n_ret   = acm_pkg::ST_INIT_WR;
                            n_state = acm_pkg::ST_NR_ISSUE;
                        end
                    end
                end
            end
            // nearest active neighbour of r_sx, lowest index on ties
            acm_pkg::ST_NR_ISSUE: begin
                if (r_y == r_n) begin
                    n_state = r_ret;
                end else if ((y_ix != r_sx) && r_active[y_ix]) begin
                    d_raddr = f_slot(r_sx, y_ix);
                    n_state = acm_pkg::ST_NR_WAIT;
                end else begin
                    n_y = r_y + CW'(1);
                end
            end
            acm_pkg::ST_NR_WAIT: begin
                if (!r_found || (r_d_rdata < r_best_lvl)) begin
                    n_found    = 1'b1;
                    n_best_idx = y_ix;
                    n_best_lvl = r_d_rdata;
                end
                n_y     = r_y + CW'(1);
                n_state = acm_pkg::ST_NR_ISSUE;
            end
            acm_pkg::ST_INIT_WR: begin
                rm_we    = 1'b1;
                rm_waddr = r_x[IW-1:0];
                rm_wdata = '{size: acm_pkg::SIZE_W'(1), nn_idx: acm_pkg::IDX_W'(nr_idx),
                             nn_lvl: nr_lvl};
                n_x = r_x + CW'(1);
                if (r_x + CW'(1) == r_n) begin
                    n_state = acm_pkg::ST_ROUND;
                end else begin
                    n_sx    = IW'(r_x + CW'(1));
                    n_y     = '0;
                    n_found = 1'b0;
                    n_state = acm_pkg::ST_NR_ISSUE;
                end
            end
            acm_pkg::ST_ROUND: begin
                if (r_left <= CW'(1)) begin
                    n_state = acm_pkg::ST_IDLE;
                end else begin
                    n_x          = '0;
                    n_pick_found = 1'b0;
                    n_state      = acm_pkg::ST_PICK_ISSUE;
                end
            end
            acm_pkg::ST_PICK_ISSUE: begin
                if (r_x == r_n) begin
                    if (!r_pick_found || (CW'(r_pick_nn) >= r_n) || (r_pick_nn == r_pick)) begin
                        n_state = acm_pkg::ST_IDLE;
                    end else begin
                        rm_raddr = r_pick_nn;
                        n_state  = acm_pkg::ST_PAIR_WAIT;
                    end
                end else if (r_active[r_x[IW-1:0]]) begin
                    rm_raddr = r_x[IW-1:0];
                    n_state  = acm_pkg::ST_PICK_WAIT;
                end else begin
                    n_x = r_x + CW'(1);
                end
            end
            acm_pkg::ST_PICK_WAIT: begin
                if (!r_pick_found || (r_r_rdata.nn_lvl < r_pick_lvl)) begin
                    n_pick_found = 1'b1;
                    n_pick       = r_x[IW-1:0];
                    n_pick_lvl   = r_r_rdata.nn_lvl;
                    n_pick_nn    = IW'(r_r_rdata.nn_idx);
                    n_pick_size  = r_r_rdata.size;
                end
                n_x     = r_x + CW'(1);
                n_state = acm_pkg::ST_PICK_ISSUE;
            end
            acm_pkg::ST_PAIR_WAIT: begin
                if (r_pick < r_pick_nn) begin
                    n_l  = r_pick;
                    n_m  = r_pick_nn;
                    n_sl = r_pick_size;
                    n_sm = r_r_rdata.size;
                end else begin
                    n_l  = r_pick_nn;
                    n_m  = r_pick;
                    n_sl = r_r_rdata.size;
                    n_sm = r_pick_size;
                end
                n_lvl                 = r_pick_lvl;
                n_active[r_pick]      = 1'b0;
                n_active[r_pick_nn]   = 1'b0;
                n_state               = acm_pkg::ST_EMIT;
            end
            acm_pkg::ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.left_object         = acm_pkg::IDX_W'(r_l);
                    n_out.right_object        = acm_pkg::IDX_W'(r_m);
                    n_out.merge_level         = r_lvl;
                    n_out.reaches_group_count = (7'(r_left) - 7'd1 == r_groups);
                    n_out.last_merge          = (r_left == CW'(2));
                    n_out_valid               = 1'b1;
                    n_x                       = '0;
                    n_state                   = acm_pkg::ST_K_ISSUE;
                end
            end
            acm_pkg::ST_K_ISSUE: begin
                if (r_x == r_n) begin
                    n_state = acm_pkg::ST_K_END;
                end else if (r_active[r_x[IW-1:0]]) begin
                    d_raddr = f_slot(r_x[IW-1:0], r_l);
                    n_state = acm_pkg::ST_K_DL;
                end else begin
                    n_x = r_x + CW'(1);
                end
            end
            acm_pkg::ST_K_DL: begin
                n_dl    = r_d_rdata;
                d_raddr = f_slot(r_x[IW-1:0], r_m);
                n_state = acm_pkg::ST_K_DM;
            end
            acm_pkg::ST_K_DM: begin
                bl_start = 1'b1;
                n_state  = acm_pkg::ST_K_BLEND;
            end
            acm_pkg::ST_K_BLEND: begin
                if (bl_done) begin
                    n_nv     = bl_value;
                    d_we     = 1'b1;
                    d_waddr  = f_slot(r_x[IW-1:0], r_l);
                    d_wdata  = bl_value;
                    rm_raddr = r_x[IW-1:0];
                    n_state  = acm_pkg::ST_K_REC;
                end
            end
            acm_pkg::ST_K_REC: begin
                n_rec_size = r_r_rdata.size;
                if (rem > CW'(1)) begin
                    if ((IW'(r_r_rdata.nn_idx) == r_l) || (IW'(r_r_rdata.nn_idx) == r_m)) begin
                        // neighbour was absorbed: rescan this cluster
                        n_sx    = r_x[IW-1:0];
                        n_y     = '0;
                        n_found = 1'b0;
                        n_ret   = acm_pkg::ST_K_REFRESH;
                        n_state = acm_pkg::ST_NR_ISSUE;
                    end else begin
                        if (r_nv < r_r_rdata.nn_lvl) begin
                            rm_we    = 1'b1;
                            rm_waddr = r_x[IW-1:0];
                            rm_wdata = '{size: r_r_rdata.size, nn_idx: acm_pkg::IDX_W'(r_l),
                                         nn_lvl: r_nv};
                        end
                        n_x     = r_x + CW'(1);
                        n_state = acm_pkg::ST_K_ISSUE;
                    end
                end else begin
                    rm_we    = 1'b1;
                    rm_waddr = r_x[IW-1:0];
                    rm_wdata = '{size: r_r_rdata.size, nn_idx: acm_pkg::IDX_W'(r_l),
                                 nn_lvl: r_nv};
                    n_x      = r_x + CW'(1);
                    n_state  = acm_pkg::ST_K_ISSUE;
                end
            end
            acm_pkg::ST_K_REFRESH: begin
                rm_we    = 1'b1;
                rm_waddr = r_x[IW-1:0];
                rm_wdata = '{size: r_rec_size, nn_idx: acm_pkg::IDX_W'(nr_idx), nn_lvl: nr_lvl};
                n_x      = r_x + CW'(1);
                n_state  = acm_pkg::ST_K_ISSUE;
            end
            acm_pkg::ST_K_END: begin
                if (rem > CW'(0)) begin
                    n_sx    = r_l;
                    n_y     = '0;
                    n_found = 1'b0;
                    n_ret   = acm_pkg::ST_L_WR;
                    n_state = acm_pkg::ST_NR_ISSUE;
                end else begin
                    n_left  = r_left - CW'(1);
                    n_state = acm_pkg::ST_ROUND;
                end
            end
            acm_pkg::ST_L_WR: begin
                rm_we         = 1'b1;
                rm_waddr      = r_l;
                rm_wdata      = '{size: r_sl + r_sm, nn_idx: acm_pkg::IDX_W'(nr_idx),
                                  nn_lvl: nr_lvl};
                n_active[r_l] = 1'b1;
                n_left        = r_left - CW'(1);
                n_state       = acm_pkg::ST_ROUND;
            end
            default: begin
                n_state = acm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- src/acm_checker.sv -----
// Port-level checks for the cluster merger, bound to the top level.
// Depends on acm_pkg and agglomerative_cluster_merger_core.
`default_nettype none

module acm_port_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire acm_pkg::t_in_item  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire acm_pkg::t_out_item o_out_data
);

    // hold a stalled merge
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled merge item changed");

    // plain matrix entries never start a run
    a_load_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_data.last_entry |=> o_in_ready)
        else $error("input refused after a plain matrix entry");

    // handshake outputs are always driven once out of reset
    a_ready_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_in_ready, o_out_valid}))
        else $error("handshake output unknown");

    // the surviving cluster is always the lower index
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.left_object < o_out_data.right_object)
        else $error("merged pair out of order");

endmodule

bind agglomerative_cluster_merger_core acm_port_checker u_acm_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ----- tb/acm_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for agglomerative_cluster_merger_core: watches the matrix, merge
// and register channels, predicts every merge and compares. Depends on acm_pkg.
module acm_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire acm_pkg::t_in_item  i_in_data,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire acm_pkg::t_out_item i_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_data,
    output int                     o_fail_count,
    output int                     o_merges_pending
);

    localparam int SLOTS = 2016;

    logic [31:0]        dist_mem [0:SLOTS-1];
    bit                 alive [0:63];
    int                 csize [0:63];
    int                 nn_idx [0:63];
    logic [31:0]        nn_lvl [0:63];

    logic [1:0]         technique;
    logic signed [15:0] beta;
    logic [6:0]         object_count;
    logic [6:0]         groups_wanted;

    acm_pkg::t_out_item merges_due[$];

    initial begin
        o_fail_count     = 0;
        o_merges_pending = 0;
    end

    function automatic int slot_of(int a, int b);
        int hi;
        int lo;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        return hi * (hi - 1) / 2 + lo;
    endfunction

    function automatic logic [31:0] dist_get(int a, int b);
        if (a == b) return 32'd0;
        return dist_mem[slot_of(a, b)];
    endfunction

    function automatic void dist_put(int a, int b, logic [31:0] v);
        if (a != b) dist_mem[slot_of(a, b)] = v;
    endfunction

    function automatic int closest(int x, int n);
        int          best;
        logic [31:0] lvl;
        bit          found;
        logic [31:0] d;
        best  = x;
        lvl   = '0;
        found = 0;
        for (int y = 0; y < n; y++) begin
            if (y == x || !alive[y]) continue;
            d = dist_get(x, y);
            if (!found || d < lvl) begin
                best  = y;
                lvl   = d;
                found = 1;
            end
        end
        return best;
    endfunction

    function automatic logic [31:0] lance_williams(logic [31:0] dl, logic [31:0] dm,
                                                   logic [31:0] dlm, int nl, int nm);
        longint tot;
        longint omb;
        longint num;
        longint den;
        longint q;
        if (technique == acm_pkg::TECH_SINGLE) return (dl < dm) ? dl : dm;
        if (technique == acm_pkg::TECH_COMPLETE) return (dl > dm) ? dl : dm;
        if (technique == acm_pkg::TECH_WPGMA) begin
            nl = 1;
            nm = 1;
        end
        tot = longint'(nl) + longint'(nm);
        omb = 64'sd32768 - longint'(beta);
        num = omb * (longint'(nl) * longint'(dl) + longint'(nm) * longint'(dm))
            + longint'(beta) * longint'(dlm) * tot;
        if (num <= 0) return 32'd0;
        den = tot * 32768;
        q   = (num + den / 2) / den;
        return (q > 64'sh0FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // Run the whole clustering pass and queue one expected item per merge.
    function automatic void cluster_pass();
        int                 n;
        int                 left_cnt;
        int                 pick;
        int                 y;
        int                 lo;
        int                 hi;
        int                 rem;
        logic [31:0]        lvl;
        logic [31:0]        nv;
        acm_pkg::t_out_item m;
        n        = (object_count > 64) ? 64 : int'(object_count);
        left_cnt = n;
        if (n < 2) return;
        for (int x = 0; x < n; x++) begin
            alive[x] = 1;
            csize[x] = 1;
        end
        for (int x = 0; x < n; x++) begin
            nn_idx[x] = closest(x, n);
            nn_lvl[x] = dist_get(x, nn_idx[x]);
        end
        while (left_cnt > 1) begin
            pick = n;
            lvl  = '0;
            for (int x = 0; x < n; x++) begin
                if (!alive[x]) continue;
                if (pick == n || nn_lvl[x] < lvl) begin
                    pick = x;
                    lvl  = nn_lvl[x];
                end
            end
            if (pick == n) break;
            y = nn_idx[pick];
            if (y >= n || y == pick) break;
            lo = (pick < y) ? pick : y;
            hi = (pick < y) ? y : pick;
            alive[lo] = 0;
            alive[hi] = 0;
            rem = left_cnt - 2;

            m.left_object         = lo[5:0];
            m.right_object        = hi[5:0];
            m.merge_level         = lvl;
            m.reaches_group_count = (left_cnt - 1 == int'(groups_wanted));
            m.last_merge          = (left_cnt - 1 == 1);
            merges_due.push_back(m);

            for (int k = 0; k < n; k++) begin
                if (!alive[k]) continue;
                nv = lance_williams(dist_get(k, lo), dist_get(k, hi), lvl,
                                    csize[lo], csize[hi]);
                dist_put(k, lo, nv);
                if (rem > 1) begin
                    if (nn_idx[k] == lo || nn_idx[k] == hi) begin
                        nn_idx[k] = closest(k, n);
                        nn_lvl[k] = dist_get(k, nn_idx[k]);
                    end else if (nv < nn_lvl[k]) begin
                        nn_idx[k] = lo;
                        nn_lvl[k] = nv;
                    end
                end else begin
                    nn_idx[k] = lo;
                    nn_lvl[k] = nv;
                end
            end
            if (rem > 0) begin
                nn_idx[lo] = closest(lo, n);
                nn_lvl[lo] = dist_get(lo, nn_idx[lo]);
                csize[lo]  = csize[lo] + csize[hi];
                alive[lo]  = 1;
            end
            left_cnt--;
        end
    endfunction

    always @(posedge i_clk) begin
        acm_pkg::t_out_item want;
        int                 lim;
        if (!i_rst_n) begin
            technique     = acm_pkg::TECH_UPGMA;
            beta          = -16'sd3277;
            object_count  = 7'd64;
            groups_wanted = 7'd1;
            for (int i = 0; i < 64; i++) begin
                alive[i]  = 0;
                csize[i]  = 1;
                nn_idx[i] = 0;
                nn_lvl[i] = '1;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    acm_pkg::CFG_TECHNIQUE:     technique     = i_cfg_data[1:0];
                    acm_pkg::CFG_BETA:          beta          = $signed(i_cfg_data);
                    acm_pkg::CFG_OBJECT_COUNT:  object_count  = i_cfg_data[6:0];
                    acm_pkg::CFG_GROUPS_WANTED: groups_wanted = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (merges_due.size() == 0) begin
                    $display("%0t: unexpected merge item %p", $time, i_out_data);
                    o_fail_count++;
                end else begin
                    want = merges_due.pop_front();
                    if (want.left_object !== i_out_data.left_object) begin
                        $display("%0t: left_object expected %0d got %0d", $time,
                                 want.left_object, i_out_data.left_object);
                        o_fail_count++;
                    end
                    if (want.right_object !== i_out_data.right_object) begin
                        $display("%0t: right_object expected %0d got %0d", $time,
                                 want.right_object, i_out_data.right_object);
                        o_fail_count++;
                    end
                    if (want.merge_level !== i_out_data.merge_level) begin
                        $display("%0t: merge_level expected %h got %h", $time,
                                 want.merge_level, i_out_data.merge_level);
                        o_fail_count++;
                    end
                    if (want.reaches_group_count !== i_out_data.reaches_group_count) begin
                        $display("%0t: reaches_group_count expected %b got %b", $time,
                                 want.reaches_group_count, i_out_data.reaches_group_count);
                        o_fail_count++;
                    end
                    if (want.last_merge !== i_out_data.last_merge) begin
                        $display("%0t: last_merge expected %b got %b", $time,
                                 want.last_merge, i_out_data.last_merge);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                lim = (object_count > 64) ? 64 : int'(object_count);
                if (i_in_data.column_index < i_in_data.row_index
                        && int'(i_in_data.row_index) < lim)
                    dist_put(int'(i_in_data.row_index), int'(i_in_data.column_index),
                             i_in_data.distance);
                if (i_in_data.last_entry) cluster_pass();
            end
        end
        o_merges_pending = merges_due.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for agglomerative_cluster_merger_core: loads matrices,
// writes registers between runs, drives the handshakes. Depends on acm_pkg, acm_checker.
module tb_top;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 3000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    acm_pkg::t_in_item  i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    acm_pkg::t_out_item o_out_data;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = '0;
    logic [15:0]       i_cfg_data = '0;

    int fail_count;
    int merges_pending;
    int cycles = 0;
    int idle_mode = 0;     // 0 none, 1 sender, 2 receiver, 3 both
    int hold_asked = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int random_items = 0;
    bit counting = 0;
    bit loaded [0:2015];

    agglomerative_cluster_merger_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    acm_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_in_data        (i_in_data),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_out_data       (o_out_data),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_merges_pending (merges_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("agglomerative_cluster_merger_core verification failed");
            $finish;
        end
    end

    // Merge receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (idle_mode == 2) begin
            i_out_ready <= ($urandom_range(0, 99) >= 52);
        end else if (idle_mode == 3) begin
            i_out_ready <= ($urandom_range(0, 99) >= 12);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic bit sender_idles();
        if (idle_mode == 1) return $urandom_range(0, 99) < 52;
        if (idle_mode == 3) return $urandom_range(0, 99) < 12;
        return 0;
    endfunction

    task automatic send_entry(acm_pkg::t_in_item it);
        if (sender_idles()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (sender_idles()) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (counting) random_items++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (merges_pending != 0) @(posedge i_clk);
        // the block may still be finishing a pass that gives no item
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [1:0] tech, logic [15:0] beta_v,
                              logic [6:0] objs, logic [6:0] groups);
        logic [15:0] vals [4];
        vals[0] = {14'd0, tech};
        vals[1] = beta_v;
        vals[2] = {9'd0, objs};
        vals[3] = {9'd0, groups};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i[1:0];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_distance(int dmode);
        case (dmode)
            1: return $urandom_range(0, 3);
            2: case ($urandom_range(0, 2))
                   0: return 32'd0;
                   1: return 32'hFFFF_FFFF;
                   default: return 32'hFFFF_FFFE;
               endcase
            3: return $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    // An entry the block must drop: column not below row, or row beyond the matrix.
    function automatic acm_pkg::t_in_item junk_entry(int n, bit last);
        acm_pkg::t_in_item it;
        int r;
        r = $urandom_range(0, 63);
        if (n < 64 && $urandom_range(0, 1)) begin
            it.row_index    = 6'($urandom_range(n, 63));
            it.column_index = 6'($urandom_range(0, 63));
        end else begin
            it.row_index    = 6'(r);
            it.column_index = 6'($urandom_range(r, 63));
        end
        it.distance   = $urandom;
        it.last_entry = last;
        return it;
    endfunction

    function automatic bit matrix_ready(int n);
        for (int s = 0; s < n * (n - 1) / 2; s++)
            if (!loaded[s]) return 0;
        return 1;
    endfunction

    task automatic cluster_run(int objs, logic [1:0] tech, logic [15:0] beta_v,
                               int groups, bit reload, int dmode, bit settle);
        int                n;
        int                pr[$];
        int                pc[$];
        int                j;
        int                t;
        acm_pkg::t_in_item it;
        n = (objs > 64) ? 64 : objs;
        if (settle) begin
            wait_drained();
            write_regs(tech, beta_v, objs[6:0], groups[6:0]);
        end
        if (!reload || n < 2) begin
            send_entry(junk_entry(n, 1'b1));
            return;
        end
        for (int r = 1; r < n; r++)
            for (int c = 0; c < r; c++) begin
                pr.push_back(r);
                pc.push_back(c);
            end
        for (int i = pr.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = pr[i]; pr[i] = pr[j]; pr[j] = t;
            t = pc[i]; pc[i] = pc[j]; pc[j] = t;
        end
        for (int i = 0; i < pr.size(); i++) begin
            if ($urandom_range(0, 7) == 0) send_entry(junk_entry(n, 1'b0));
            it.row_index    = 6'(pr[i]);
            it.column_index = 6'(pc[i]);
            it.distance     = pick_distance(dmode);
            it.last_entry   = (i == pr.size() - 1);
            loaded[pr[i] * (pr[i] - 1) / 2 + pc[i]] = 1;
            send_entry(it);
        end
    endtask

    initial begin
        int          objs;
        int          runs;
        logic [15:0] beta_v;
        for (int s = 0; s < 2016; s++) loaded[s] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: smallest matrix, ties, saturation, cut flags, reruns
        cluster_run(2, acm_pkg::TECH_SINGLE, 16'd0, 1, 1, 0, 1);
        cluster_run(4, acm_pkg::TECH_COMPLETE, 16'd0, 2, 1, 1, 1);
        cluster_run(5, acm_pkg::TECH_UPGMA, 16'h8000, 0, 1, 2, 1);
        cluster_run(5, acm_pkg::TECH_WPGMA, 16'h7FFF, 5, 1, 2, 1);
        cluster_run(6, acm_pkg::TECH_UPGMA, 16'hF333, 64, 1, 3, 1);
        cluster_run(6, acm_pkg::TECH_UPGMA, 16'hF333, 64, 0, 3, 0);
        cluster_run(1, acm_pkg::TECH_SINGLE, 16'd0, 1, 1, 0, 1);
        cluster_run(0, acm_pkg::TECH_COMPLETE, 16'd0, 0, 1, 0, 1);
        idle_mode = 3;
        cluster_run(12, acm_pkg::TECH_SINGLE, 16'd0, 7, 1, 0, 1);

        // random runs, rotating through the idling phases
        counting = 1;
        runs = 0;
        while (random_items < 250) begin
            idle_mode = runs % 4;
            objs = $urandom_range(2, 12);
            case ($urandom_range(0, 7))
                0: beta_v = 16'h8000;
                1: beta_v = 16'h7FFF;
                default: beta_v = 16'($urandom_range(0, 16'hFFFF));
            endcase
            cluster_run(objs, 2'($urandom_range(0, 3)), beta_v, $urandom_range(0, objs + 1),
                        !matrix_ready(objs) || $urandom_range(0, 3) != 0,
                        $urandom_range(0, 3), 1);
            if (runs == 3) begin
                // hold the merge side while the next matrix presses on the input
                hold_asked++;
                cluster_run(objs, acm_pkg::TECH_SINGLE, 16'd0, 0, 1,
                            $urandom_range(0, 3), 0);
            end
            runs++;
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("agglomerative_cluster_merger_core verification clean");
        else
            $display("agglomerative_cluster_merger_core verification failed");
        $finish;
    end

endmodule
